>>> design/oled_text_glyph_streamer_defines.svh
// Assertion macros for the checker file of the text glyph streamer.
`ifndef OLED_TEXT_GLYPH_STREAMER_DEFINES_SVH
`define OLED_TEXT_GLYPH_STREAMER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define OTGS_ASSERT_SAME(lbl, clk_s, off_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (off_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define OTGS_ASSERT_NEXT(lbl, clk_s, off_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (off_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/otgs_pkg.sv
// Shared constants and types of the text glyph streamer.
package otgs_pkg;

  localparam int COLUMNS_DEF   = 128;
  localparam int LAST_PAGE_DEF = 7;
  localparam int GLYPH_WIDTH   = 5;
  localparam int FONT_ROWS     = 95;
  localparam int FONT_AW       = $clog2(FONT_ROWS);

  // Bytes of one glyph: glyph columns plus the spacer; the cursor sequence is as long.
  localparam int SEQ_LEN = GLYPH_WIDTH + 1;
  localparam int STEP_W  = $clog2(SEQ_LEN);

  localparam logic [7:0] CMD_COL_RANGE  = 8'h21;
  localparam logic [7:0] CMD_PAGE_RANGE = 8'h22;
  localparam logic [7:0] FIRST_CODE     = 8'h20;
  localparam logic [7:0] LAST_CODE      = 8'h7E;
  localparam logic [7:0] NEWLINE        = 8'h0A;
  localparam logic [7:0] BLANK          = 8'h00;

  typedef logic [0:GLYPH_WIDTH-1][7:0] glyph_row_t;

  // What one accepted request will emit.
  typedef struct packed {
    logic       cmd_en;
    logic       glyph_en;
    logic [7:0] cmd_col;
    logic [7:0] cmd_page;
  } otgs_plan_t;

endpackage

>>> design/otgs_font_rom.sv
// 5x8 font ROM with a registered read port, one glyph row per read.
module otgs_font_rom (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [otgs_pkg::FONT_AW-1:0]  addr,
  output otgs_pkg::glyph_row_t          row
);
  import otgs_pkg::*;

  localparam glyph_row_t FONT [FONT_ROWS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h2f,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7f,8'h14,8'h7f,8'h14},
    '{8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1c,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h00,8'hA0,8'h60,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h59,8'h51,8'h3E}, '{8'h7C,8'h12,8'h11,8'h12,8'h7C},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h55,8'hAA,8'h55,8'hAA,8'h55}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h03,8'h05,8'h00,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h18,8'hA4,8'hA4,8'hA4,8'h7C},
    '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
    '{8'h40,8'h80,8'h84,8'h7D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'hFC,8'h24,8'h24,8'h24,8'h18}, '{8'h18,8'h24,8'h24,8'h18,8'hFC},
    '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h1C,8'hA0,8'hA0,8'hA0,8'h7C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h10,8'h7C,8'h82,8'h00},
    '{8'h00,8'h00,8'hFF,8'h00,8'h00}, '{8'h00,8'h82,8'h7C,8'h10,8'h00},
    '{8'h00,8'h06,8'h09,8'h09,8'h06}
  };

  // Read one glyph row; the row holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row <= FONT[addr];
    end
  end

endmodule

>>> design/otgs_cursor.sv
// Cursor state and the per-request plan: cursor commands, glyph, font address.
module otgs_cursor #(
  parameter int COLUMNS   = otgs_pkg::COLUMNS_DEF,
  parameter int LAST_PAGE = otgs_pkg::LAST_PAGE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic                         kind,
  input  logic [7:0]                   char_code,
  input  logic [7:0]                   page,
  input  logic [7:0]                   column,
  output otgs_pkg::otgs_plan_t         plan,
  output logic [otgs_pkg::FONT_AW-1:0] font_addr
);
  import otgs_pkg::*;

  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int CW1   = COL_W + 1;
  localparam int PG_W  = $clog2(LAST_PAGE + 1);

  logic [PG_W-1:0]  cur_page;
  logic [PG_W-1:0]  cur_page_next;
  logic [COL_W-1:0] cur_col;
  logic [COL_W-1:0] cur_col_next;
  logic [PG_W-1:0]  wrap_page;
  logic [CW1-1:0]   col_reach;
  logic             set_ok;
  logic             newline;
  logic             wrap;
  logic             printable;

  // Decide what the request emits and where the cursor ends up
  always_comb begin
    set_ok    = (page <= 8'(LAST_PAGE)) && ({1'b0, column} < 9'(COLUMNS));
    newline   = (char_code == NEWLINE);
    col_reach = {1'b0, cur_col} + CW1'(GLYPH_WIDTH);
    wrap      = newline || (col_reach >= CW1'(COLUMNS));
    wrap_page = (cur_page >= PG_W'(LAST_PAGE)) ? '0 : cur_page + PG_W'(1);
    printable = (char_code >= FIRST_CODE) && (char_code <= LAST_CODE);
    font_addr = printable ? FONT_AW'(char_code - FIRST_CODE) : '0;

    plan          = '0;
    cur_page_next = cur_page;
    cur_col_next  = cur_col;
    if (kind) begin
      if (set_ok) begin
        plan.cmd_en   = 1'b1;
        plan.cmd_col  = column;
        plan.cmd_page = page;
        cur_page_next = PG_W'(page);
        cur_col_next  = COL_W'(column);
      end
    end else begin
      if (wrap) begin
        plan.cmd_en   = 1'b1;
        plan.cmd_col  = BLANK;
        plan.cmd_page = 8'(wrap_page);
        cur_page_next = wrap_page;
        cur_col_next  = '0;
      end
      if (!newline) begin
        plan.glyph_en = 1'b1;
        cur_col_next  = (wrap ? '0 : cur_col) + COL_W'(SEQ_LEN);
      end
    end
  end

  // Commit the cursor when a request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_page <= '0;
      cur_col  <= '0;
    end else if (take) begin
      cur_page <= cur_page_next;
      cur_col  <= cur_col_next;
    end
  end

endmodule

>>> design/otgs_byte_seq.sv
// Byte sequencer: walks the cursor commands and glyph bytes into the output register.
module otgs_byte_seq #(
  parameter int COLUMNS   = otgs_pkg::COLUMNS_DEF,
  parameter int LAST_PAGE = otgs_pkg::LAST_PAGE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  otgs_pkg::otgs_plan_t   plan,
  input  otgs_pkg::glyph_row_t   row,
  input  logic                   out_stall,
  output logic                   ready,
  output logic                   out_valid,
  output logic                   is_command,
  output logic [7:0]             out_byte,
  output logic                   last
);
  import otgs_pkg::*;

  // Cursor sequence steps
  localparam logic [STEP_W-1:0] C_OP_COL   = STEP_W'(0);
  localparam logic [STEP_W-1:0] C_COL      = STEP_W'(1);
  localparam logic [STEP_W-1:0] C_COL_END  = STEP_W'(2);
  localparam logic [STEP_W-1:0] C_OP_PAGE  = STEP_W'(3);
  localparam logic [STEP_W-1:0] C_PAGE     = STEP_W'(4);
  localparam logic [STEP_W-1:0] C_PAGE_END = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_END   = STEP_W'(SEQ_LEN - 1);

  logic              active;
  logic              cmd_pending;
  logic              glyph_pending;
  logic [STEP_W-1:0] step;
  logic [7:0]        cmd_col;
  logic [7:0]        cmd_page;
  logic              out_adv;
  logic              emit;
  logic              at_end;
  logic              fin;
  logic [7:0]        byte_sel;

  // Handshake and end-of-request detection
  always_comb begin
    out_adv = !out_valid || !out_stall;
    emit    = active && out_adv;
    at_end  = (step == STEP_END);
    fin     = at_end && !(cmd_pending && glyph_pending);
    ready   = !active || (emit && fin);
  end

  // Select the byte for the current step
  always_comb begin
    byte_sel = BLANK;
    if (cmd_pending) begin
      unique case (step)
        C_OP_COL:   byte_sel = CMD_COL_RANGE;
        C_COL:      byte_sel = cmd_col;
        C_COL_END:  byte_sel = 8'(COLUMNS - 1);
        C_OP_PAGE:  byte_sel = CMD_PAGE_RANGE;
        C_PAGE:     byte_sel = cmd_page;
        C_PAGE_END: byte_sel = 8'(LAST_PAGE);
        default:    byte_sel = BLANK;
      endcase
    end else if (step < STEP_W'(GLYPH_WIDTH)) begin
      byte_sel = row[step];
    end
  end

  // Advance the step counter and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      cmd_pending   <= 1'b0;
      glyph_pending <= 1'b0;
      step          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid <= emit;
      end
      if (emit) begin
        if (at_end) begin
          step <= '0;
          if (fin) begin
            active <= 1'b0;
          end else begin
            cmd_pending <= 1'b0;
          end
        end else begin
          step <= step + STEP_W'(1);
        end
      end
      if (take) begin
        active        <= plan.cmd_en || plan.glyph_en;
        cmd_pending   <= plan.cmd_en;
        glyph_pending <= plan.glyph_en;
        step          <= '0;
      end
    end
  end

  // Hold the request payload and load the output register
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_col  <= plan.cmd_col;
      cmd_page <= plan.cmd_page;
    end
    if (emit) begin
      is_command <= cmd_pending;
      out_byte   <= byte_sel;
      last       <= fin;
    end
  end

endmodule

>>> design/oled_text_glyph_streamer.sv
// A taken request first loads the sequencer; its first byte then enters the output register unless stalled.
// Throughput: one byte per cycle while the output is not stalled; a request emits the cursor sequence (set-cursor),
//   the glyph bytes and spacer (glyph) or both (line wrap plus glyph); a rejected set-cursor request emits nothing.
// The next request is taken in the cycle its predecessor's final byte enters the output register.
// Reset (synchronous): cursor to page 0, column 0; output register and sequencer empty.
module oled_text_glyph_streamer #(
  parameter int COLUMNS   = otgs_pkg::COLUMNS_DEF,
  parameter int LAST_PAGE = otgs_pkg::LAST_PAGE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] char_code,
  input  logic [7:0] page,
  input  logic [7:0] column,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_command,
  output logic [7:0] out_byte,
  output logic       last
);
  import otgs_pkg::*;

  logic                take;
  logic                seq_ready;
  otgs_plan_t          plan;
  logic [FONT_AW-1:0]  font_addr;
  glyph_row_t          glyph_row;

  // Take a request whenever the sequencer can start it
  assign in_stall = !seq_ready;
  assign take     = in_valid && seq_ready;

  otgs_cursor #(
    .COLUMNS   (COLUMNS),
    .LAST_PAGE (LAST_PAGE)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .kind      (kind),
    .char_code (char_code),
    .page      (page),
    .column    (column),
    .plan      (plan),
    .font_addr (font_addr)
  );

  otgs_font_rom u_font_rom (
    .clk   (clk),
    .rd_en (take),
    .addr  (font_addr),
    .row   (glyph_row)
  );

  otgs_byte_seq #(
    .COLUMNS   (COLUMNS),
    .LAST_PAGE (LAST_PAGE)
  ) u_byte_seq (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .plan       (plan),
    .row        (glyph_row),
    .out_stall  (out_stall),
    .ready      (seq_ready),
    .out_valid  (out_valid),
    .is_command (is_command),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule

>>> design/otgs_checker.sv
// Port-level checker for the text glyph streamer, bound to the top level.
`include "oled_text_glyph_streamer_defines.svh"

module otgs_checker #(
  parameter int LAST_PAGE = otgs_pkg::LAST_PAGE_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       kind,
  input logic [7:0] char_code,
  input logic [7:0] page,
  input logic [7:0] column,
  input logic       out_valid,
  input logic       out_stall,
  input logic       is_command,
  input logic [7:0] out_byte,
  input logic       last
);

  // A stalled request holds its fields
  `OTGS_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(kind) && $stable(char_code) && $stable(page) && $stable(column), "stalled request changed")

  // A stalled byte holds its fields
  `OTGS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(is_command) && $stable(last), "stalled output byte changed")

  // Reset empties the output register
  `OTGS_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !out_valid, "output valid after reset")

  // A request ending in a command ends with the last page
  `OTGS_ASSERT_SAME(a_cursor_end, clk, rst, out_valid && is_command && last, out_byte == 8'(LAST_PAGE), "cursor sequence ends wrong")

  // A request ending in data ends with the blank spacer
  `OTGS_ASSERT_SAME(a_spacer, clk, rst, out_valid && !is_command && last, out_byte == 8'h00, "glyph spacer not blank")

endmodule

bind oled_text_glyph_streamer otgs_checker #(
  .LAST_PAGE (LAST_PAGE)
) u_otgs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .kind       (kind),
  .char_code  (char_code),
  .page       (page),
  .column     (column),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .is_command (is_command),
  .out_byte   (out_byte),
  .last       (last)
);
